/* rtl/i2a_pkg.sv */
// Package for the integer to ASCII digits unit: widths, ASCII codes,
// controller state type, control/status structs and the digit character map.
// No dependencies.
package i2a_pkg;

	localparam int VALUE_W   = 64;
	localparam int WIDTH_W   = 7;
	localparam int CHAR_W    = 7;
	localparam int NIB_W     = 4;
	localparam int BIT_CNT_W = $clog2(VALUE_W + 1);

	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_LOW_A = 7'h61;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 7'h41;
	localparam logic [NIB_W-1:0]  DEC_BASE = 4'd10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_SKIP,
		ST_EMIT
	} state_t;

	// Commands from the controller to the digit register
	typedef struct packed {
		logic load;
		logic hex;
		logic shift;
	} conv_cmd_t;

	// Status from the digit register back to the controller
	typedef struct packed {
		logic             done;
		logic [NIB_W-1:0] top;
	} conv_sts_t;

	// One digit value to its ASCII character
	function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] d,
		input logic upper);
		logic [CHAR_W-1:0] base_ch;
		base_ch = upper ? CH_UP_A : CH_LOW_A;
		if (d < DEC_BASE) begin
			digit_char = CH_ZERO + {3'b000, d};
		end else begin
			digit_char = base_ch + {3'b000, d} - {3'b000, DEC_BASE};
		end
	endfunction

endpackage

/* rtl/i2a_if.sv */
// Valid/ready channel interfaces for the integer to ASCII digits unit:
// the number request channel and the character result channel.
// Depends on i2a_pkg.
interface i2a_in_if import i2a_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic               is_hex;
	logic               signed_mode;
	logic               uppercase;
	logic [WIDTH_W-1:0] width_bits;

	modport source (output valid, value, is_hex, signed_mode, uppercase, width_bits,
		input ready);
	modport sink (input valid, value, is_hex, signed_mode, uppercase, width_bits,
		output ready);
endinterface

interface i2a_out_if import i2a_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last;

	modport source (output valid, character, last, input ready);
	modport sink (input valid, character, last, output ready);
endinterface

/* rtl/i2a_digit_reg.sv */
// Digit register: bit-serial binary to BCD conversion (shift and add three),
// direct nibble load for hex, and a nibble-wide left shift for emission.
// Depends on i2a_pkg.
module i2a_digit_reg import i2a_pkg::*; #(
	parameter int DIGIT_SLOTS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  conv_cmd_t          cmd,
	input  logic [VALUE_W-1:0] load_value,
	output conv_sts_t          sts
);

	localparam int DW = DIGIT_SLOTS * NIB_W;

	logic [DW-1:0]        digits_q;
	logic [DW-1:0]        adj;
	logic [VALUE_W-1:0]   bin_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;

	// Add three to every digit lane of five or more before the next shift
	always_comb begin
		for (int i = 0; i < DIGIT_SLOTS; i++) begin
			if (digits_q[i*NIB_W +: NIB_W] >= 4'd5) begin
				adj[i*NIB_W +: NIB_W] = digits_q[i*NIB_W +: NIB_W] + 4'd3;
			end else begin
				adj[i*NIB_W +: NIB_W] = digits_q[i*NIB_W +: NIB_W];
			end
		end
	end

	// Bit counter: control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
		end else if (cmd.load) begin
			bit_cnt_q <= cmd.hex ? '0 : BIT_CNT_W'(VALUE_W);
		end else if (bit_cnt_q != '0) begin
			bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
		end
	end

	// Digit and binary shift registers: one binary bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= load_value;
			if (cmd.hex) begin
				digits_q <= DW'(load_value);
			end else begin
				digits_q <= '0;
			end
		end else if (bit_cnt_q != '0) begin
			digits_q <= {adj[DW-2:0], bin_q[VALUE_W-1]};
			bin_q    <= {bin_q[VALUE_W-2:0], 1'b0};
		end else if (cmd.shift) begin
			digits_q <= {digits_q[DW-NIB_W-1:0], {NIB_W{1'b0}}};
		end
	end

	assign sts.done = (bit_cnt_q == '0);
	assign sts.top  = digits_q[DW-1 -: NIB_W];

endmodule

/* rtl/integer_to_ascii_digits_unit.sv */
// Top level of the integer to ASCII digits unit: request capture, sign and
// width handling, controller and output register. Depends on i2a_pkg,
// i2a_if and i2a_digit_reg.
//
// Usage: one transaction on req carries a 64-bit number and its format
// (is_hex, signed_mode, uppercase, width_bits). The unit answers with one
// transaction per character on rsp: an optional '-' and then the digits,
// most significant first, with last set on the final digit. Zero gives "0".
// Both channels are valid/ready; a transaction moves when both are high.
// One number is in work at a time; req.ready is high only while idle.
// Steps per number: capture, then the bit-serial decimal conversion (one
// shift per bit of the 64-bit value; none for hex), a minus sign if any,
// leaving the leading-zero skip, and the digit register shifting out past
// its leading zeros while the digits are emitted.
// A registered output stage holds each character; when rsp stalls the unit
// simply waits, nothing is dropped. Reset empties the output stage and
// returns the controller to idle.
module integer_to_ascii_digits_unit import i2a_pkg::*; #(
	parameter int DIGIT_SLOTS = 20
) (
	input logic      clk,
	input logic      arst_n,
	i2a_in_if.sink   req,
	i2a_out_if.source rsp
);

	localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);

	state_t             state_q, state_d;
	conv_cmd_t          cmd;
	conv_sts_t          sts;
	logic [VALUE_W-1:0] mag;
	logic               neg;
	logic               neg_q;
	logic               upper_q;
	logic [CNT_W-1:0]   left_q;
	logic               left_dec;
	logic               accept;
	logic               slot_free;
	logic               emit;
	logic [CHAR_W-1:0]  emit_char;
	logic               emit_last;
	logic               skip_zero;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	assign accept    = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;
	assign skip_zero = (sts.top == '0) && (left_q > CNT_W'(1));

	// Sign handling, then masking to the given width
	always_comb begin
		logic [VALUE_W-1:0] signed_mag;
		neg        = req.signed_mode && req.value[VALUE_W-1];
		signed_mag = neg ? (VALUE_W'(0) - req.value) : req.value;
		if (req.width_bits < WIDTH_W'(VALUE_W)) begin
			mag = signed_mag & ~({VALUE_W{1'b1}} << req.width_bits[5:0]);
		end else begin
			mag = signed_mag;
		end
	end

	i2a_digit_reg #(
		.DIGIT_SLOTS(DIGIT_SLOTS)
	) u_digit_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.load_value (mag),
		.sts        (sts)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (sts.done) state_d = neg_q ? ST_SIGN : ST_SKIP;
			end
			ST_SIGN: begin
				if (slot_free) state_d = ST_SKIP;
			end
			ST_SKIP: begin
				if (!skip_zero) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free && left_q == CNT_W'(1)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Controller outputs
	always_comb begin
		req.ready = 1'b0;
		cmd       = '0;
		left_dec  = 1'b0;
		emit      = 1'b0;
		emit_char = CH_ZERO;
		emit_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				cmd.load  = req.valid;
				cmd.hex   = req.is_hex;
			end
			ST_CONV: begin
			end
			ST_SIGN: begin
				emit      = slot_free;
				emit_char = CH_MINUS;
			end
			ST_SKIP: begin
				cmd.shift = skip_zero;
				left_dec  = skip_zero;
			end
			ST_EMIT: begin
				emit      = slot_free;
				emit_char = digit_char(sts.top, upper_q);
				emit_last = (left_q == CNT_W'(1));
				cmd.shift = slot_free;
				left_dec  = slot_free;
			end
			default: begin
			end
		endcase
	end

	// Controller registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			left_q  <= '0;
			neg_q   <= 1'b0;
			upper_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				left_q  <= CNT_W'(DIGIT_SLOTS);
				neg_q   <= neg;
				upper_q <= req.uppercase;
			end else if (left_dec) begin
				left_q <= left_q - CNT_W'(1);
			end
		end
	end

	// Output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.character = char_q;
	assign rsp.last      = last_q;

endmodule
